/* design/pst_pkg.sv */
package pst_pkg;

    // Geometry and fixed-point format.
    localparam int COORD_WIDTH  = 16;
    localparam int FRAC_BITS    = 8;
    localparam int CORDIC_STEPS = 16;
    localparam int NPTS         = 4;

    // Field widths of the stream and configuration items.
    localparam int ACT_W       = 3;
    localparam int OP_W        = 24;
    localparam int CEN_W       = 12;
    localparam int IDX_W       = 2;
    localparam int MODEL_W     = 16;
    localparam int SCREEN_W    = 17;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 2;

    localparam logic [ACT_W-1:0] ACT_TRANSLATE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SCALE     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ROTATE    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SHEAR     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PROJECT   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;

    // Multiply-accumulate datapath widths.
    localparam int PROD_W = OP_W + COORD_WIDTH;
    localparam int ACC_W  = PROD_W + 1;
    localparam int SUM_W  = ACC_W + 1;

    // Cosine and sine in signed Q.FRAC_BITS, magnitude up to one.
    localparam int CS_W = FRAC_BITS + 2;

    // Angle reduction constants in Q.FRAC_BITS degrees.
    localparam longint FULL_DEG    = longint'(360) << FRAC_BITS;
    localparam longint HALF_DEG    = longint'(180) << FRAC_BITS;
    localparam longint QUARTER_DEG = longint'(90) << FRAC_BITS;

    function automatic int mod_steps();
        int     k;
        longint m;
        k = 0;
        m = FULL_DEG;
        while (m < (longint'(1) << (OP_W - 1))) begin
            m = m << 1;
            k = k + 1;
        end
        return k;
    endfunction

    localparam int     MOD_K        = mod_steps();
    localparam longint FULL_SHIFTED = FULL_DEG << MOD_K;
    localparam int     MOD_W        = $clog2(FULL_SHIFTED << 1) + 2;
    localparam int     MCNT_W       = (MOD_K > 0) ? $clog2(MOD_K + 1) : 1;

    // CORDIC datapath: x and y in Q.30, residual angle in Q.16 degrees.
    localparam int     XY_W        = 33;
    localparam int     Z_W         = 26;
    localparam int     ST_W        = $clog2(CORDIC_STEPS);
    localparam longint CORDIC_GAIN = 64'd652032874;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = Z_W'(2949120);
            5'd1:    v = Z_W'(1740967);
            5'd2:    v = Z_W'(919879);
            5'd3:    v = Z_W'(466945);
            5'd4:    v = Z_W'(234379);
            5'd5:    v = Z_W'(117265);
            5'd6:    v = Z_W'(58666);
            5'd7:    v = Z_W'(29335);
            5'd8:    v = Z_W'(14668);
            5'd9:    v = Z_W'(7334);
            5'd10:   v = Z_W'(3667);
            5'd11:   v = Z_W'(1833);
            5'd12:   v = Z_W'(917);
            5'd13:   v = Z_W'(458);
            5'd14:   v = Z_W'(229);
            5'd15:   v = Z_W'(115);
            5'd16:   v = Z_W'(57);
            5'd17:   v = Z_W'(29);
            5'd18:   v = Z_W'(14);
            5'd19:   v = Z_W'(7);
            5'd20:   v = Z_W'(4);
            5'd21:   v = Z_W'(2);
            5'd22:   v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [CS_W-1:0]        t_trig;

    // Per-phase controls for the shared multiply-accumulate unit.
    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
        logic acc_trunc;
    } t_mac_ctl;

endpackage

/* design/pst_cordic.sv */
module pst_cordic (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [pst_pkg::OP_W-1:0] i_angle,
    output logic                      o_done,
    output pst_pkg::t_trig            o_cos,
    output pst_pkg::t_trig            o_sin
);
    import pst_pkg::*;

    localparam logic [2:0] C_IDLE  = 3'd0;
    localparam logic [2:0] C_MOD   = 3'd1;
    localparam logic [2:0] C_FOLD1 = 3'd2;
    localparam logic [2:0] C_FOLD2 = 3'd3;
    localparam logic [2:0] C_ITER  = 3'd4;
    localparam logic [2:0] C_ROUND = 3'd5;

    localparam int RSH = 30 - FRAC_BITS;
    localparam logic signed [XY_W-1:0]  RND     = XY_W'(longint'(1) << (RSH - 1));
    localparam logic signed [MOD_W-1:0] FULL_M  = MOD_W'(FULL_DEG);
    localparam logic signed [MOD_W-1:0] HALF_M  = MOD_W'(HALF_DEG);
    localparam logic signed [MOD_W-1:0] QUART_M = MOD_W'(QUARTER_DEG);

    logic [2:0]              r_state;
    logic signed [MOD_W-1:0] r_v;
    logic signed [MOD_W-1:0] r_dv;
    logic [MCNT_W-1:0]       r_mcnt;
    logic                    r_neg;
    logic signed [XY_W-1:0]  r_x;
    logic signed [XY_W-1:0]  r_y;
    logic signed [Z_W-1:0]   r_z;
    logic [ST_W-1:0]         r_i;
    logic                    r_done;
    t_trig                   r_cos;
    t_trig                   r_sin;

    logic signed [MOD_W-1:0] folded;
    logic                    fold_neg;
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    logic signed [Z_W-1:0]   at;
    logic signed [XY_W-1:0]  c_rnd;
    logic signed [XY_W-1:0]  s_rnd;
    t_trig                   c_q;
    t_trig                   s_q;

    always_comb begin
        folded   = r_v;
        fold_neg = 1'b0;
        if (r_v > QUART_M) begin
            folded   = r_v - HALF_M;
            fold_neg = 1'b1;
        end else if (r_v < -QUART_M) begin
            folded   = r_v + HALF_M;
            fold_neg = 1'b1;
        end
        dx    = r_y >>> r_i;
        dy    = r_x >>> r_i;
        at    = atan_q16(5'(r_i));
        c_rnd = (r_x + RND) >>> RSH;
        s_rnd = (r_y + RND) >>> RSH;
        c_q   = c_rnd[CS_W-1:0];
        s_q   = s_rnd[CS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            // The done pulse follows the rounding cycle.
            r_done <= (r_state == C_ROUND);
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        // Bias negative angles up by a multiple of a full turn.
                        r_v     <= MOD_W'(i_angle) + MOD_W'(FULL_SHIFTED);
                        r_dv    <= MOD_W'(FULL_SHIFTED);
                        r_mcnt  <= MCNT_W'(MOD_K);
                        r_state <= C_MOD;
                    end
                end
                C_MOD: begin
                    if (r_v >= r_dv) begin
                        r_v <= r_v - r_dv;
                    end
                    r_dv <= r_dv >>> 1;
                    if (r_mcnt == '0) begin
                        r_state <= C_FOLD1;
                    end else begin
                        r_mcnt <= r_mcnt - 1'b1;
                    end
                end
                C_FOLD1: begin
                    if (r_v >= HALF_M) begin
                        r_v <= r_v - FULL_M;
                    end
                    r_state <= C_FOLD2;
                end
                C_FOLD2: begin
                    r_neg   <= fold_neg;
                    r_z     <= Z_W'(folded) <<< (16 - FRAC_BITS);
                    r_x     <= XY_W'(CORDIC_GAIN);
                    r_y     <= '0;
                    r_i     <= '0;
                    r_state <= C_ITER;
                end
                C_ITER: begin
                    if (!r_z[Z_W-1]) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + at;
                    end
                    if (r_i == ST_W'(CORDIC_STEPS - 1)) begin
                        r_state <= C_ROUND;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                C_ROUND: begin
                    r_cos   <= r_neg ? -c_q : c_q;
                    r_sin   <= r_neg ? -s_q : s_q;
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

/* design/pst_mac.sv */
module pst_mac (
    input  logic                            i_clk,
    input  pst_pkg::t_mac_ctl               i_ctl,
    input  logic signed [pst_pkg::OP_W-1:0] i_op_a,
    input  pst_pkg::t_coord                 i_op_b,
    input  pst_pkg::t_coord                 i_addend,
    output pst_pkg::t_coord                 o_result
);
    import pst_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((longint'(1) << (COORD_WIDTH - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
    localparam logic signed [ACC_W-1:0] TRUNC_BIAS =
        ACC_W'((longint'(1) << FRAC_BITS) - 1);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  bias;
    logic signed [SUM_W-1:0]  sum;

    always_comb begin
        // Rounding towards zero: negative values get the bias before the shift.
        bias = r_acc[ACC_W-1] ? TRUNC_BIAS : '0;
        sum  = SUM_W'(r_acc) + SUM_W'(i_addend);
        if (sum > SAT_HI) begin
            o_result = SAT_HI[COORD_WIDTH-1:0];
        end else if (sum < SAT_LO) begin
            o_result = SAT_LO[COORD_WIDTH-1:0];
        end else begin
            o_result = sum[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
        if (i_ctl.acc_load) begin
            r_acc <= ACC_W'(r_prod);
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end else if (i_ctl.acc_trunc) begin
            r_acc <= (r_acc + bias) >>> FRAC_BITS;
        end
    end

endmodule

/* design/point_set_2d_transform_unit.sv */
// A rotation first waits for its sine and cosine from the iterative CORDIC unit; then every
// item has its eight coordinates worked through the shared multiplier in turn.
// A new item is taken only once the last report of the previous one is in the output
// register, so items are not overlapped.
// Reset (synchronous, active low) restores the points and the screen centre registers.
module point_set_2d_transform_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input items.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata, lowest bit first: operand_a[23:0], operand_b[47:24].
    input  logic [pst_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser, lowest bit first: action[2:0].
    input  logic [pst_pkg::ACT_W-1:0]       i_s_axis_tuser,
    // Result items.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata, lowest bit first: point_index[1:0], model_x[17:2], model_y[33:18],
    // screen_x[50:34], screen_y[67:51], zeros.
    output logic [pst_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                            o_m_axis_tlast,
    // Configuration writes.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pst_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pst_pkg::CEN_W-1:0]       i_cfg_data
);
    import pst_pkg::*;

    // The sequencer waits in S_TRIG for sine and cosine, walks the coordinates in S_PT and
    // hands the four points to the output register in S_OUT.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TRIG = 2'd1;
    localparam logic [1:0] S_PT   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // Phases of one coordinate in the multiply-accumulate unit.
    localparam logic [2:0] PH_MUL1  = 3'd0;
    localparam logic [2:0] PH_MUL2  = 3'd1;
    localparam logic [2:0] PH_SUM   = 3'd2;
    localparam logic [2:0] PH_TRUNC = 3'd3;
    localparam logic [2:0] PH_WRITE = 3'd4;

    localparam int CALC_W = COORD_WIDTH + CEN_W + 2;
    localparam int PAD_W  = OUT_TDATA_W - (IDX_W + 2 * MODEL_W + 2 * SCREEN_W);

    localparam logic signed [OP_W-1:0] A_ONE = OP_W'(1);
    localparam t_coord                 B_ONE = COORD_WIDTH'(1);

    logic [1:0]               r_state;
    logic [ACT_W-1:0]         r_action;
    logic signed [OP_W-1:0]   r_op_a;
    logic signed [OP_W-1:0]   r_op_b;
    t_trig                    r_cos;
    t_trig                    r_sin;
    // Points are kept as a ring: the point being worked on or sent sits in entries 0 and 1,
    // and each finished point moves to the tail.
    t_coord                   r_pt [2*NPTS];
    logic                     r_sel;
    logic [2:0]               r_ph;
    logic [IDX_W-1:0]         r_pcnt;
    t_coord                   r_new_x;
    logic [CEN_W-1:0]         r_cx;
    logic [CEN_W-1:0]         r_cy;
    logic                     r_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data;
    logic                     r_out_last;

    logic                     in_accept;
    logic [ACT_W-1:0]         in_action;
    logic signed [OP_W-1:0]   in_op_a;
    logic signed [OP_W-1:0]   in_op_b;
    logic                     cordic_start;
    logic                     cordic_done;
    t_trig                    cordic_cos;
    t_trig                    cordic_sin;

    t_coord                   self_c;
    t_coord                   other_c;
    logic signed [OP_W-1:0]   op_c;
    logic signed [OP_W-1:0]   cos_a;
    logic signed [OP_W-1:0]   sin_a;
    logic signed [OP_W-1:0]   t1_a;
    t_coord                   t1_b;
    logic signed [OP_W-1:0]   t2_a;
    t_coord                   t2_b;
    logic                     div_mode;
    t_mac_ctl                 mac_ctl;
    logic signed [OP_W-1:0]   mac_a;
    t_coord                   mac_b;
    t_coord                   mac_addend;
    t_coord                   mac_result;
    logic                     out_load;

    logic signed [CALC_W-1:0] cx_s;
    logic signed [CALC_W-1:0] cy_s;
    logic signed [CALC_W-1:0] px;
    logic signed [CALC_W-1:0] py;
    logic signed [CALC_W-1:0] scr_x;
    logic signed [CALC_W-1:0] scr_y;

    // Neither channel takes an item while reset is held.
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign in_action       = i_s_axis_tuser;
    assign in_op_a         = i_s_axis_tdata[0 +: OP_W];
    assign in_op_b         = i_s_axis_tdata[OP_W +: OP_W];
    assign cordic_start    = in_accept && (in_action == ACT_ROTATE);
    assign o_s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign o_cfg_ready     = i_rst_n;

    pst_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (in_op_a),
        .o_done  (cordic_done),
        .o_cos   (cordic_cos),
        .o_sin   (cordic_sin)
    );

    // Operand selection for the two product terms of the current coordinate. The first
    // coordinate of a point is x (self is x, other is y), the second is y.
    always_comb begin
        self_c   = r_sel ? r_pt[1] : r_pt[0];
        other_c  = r_sel ? r_pt[0] : r_pt[1];
        op_c     = r_sel ? r_op_b : r_op_a;
        cos_a    = OP_W'(r_cos);
        sin_a    = OP_W'(r_sin);
        t1_a     = A_ONE;
        t1_b     = self_c;
        t2_a     = '0;
        t2_b     = '0;
        div_mode = r_action inside {ACT_ROTATE, ACT_SHEAR, ACT_PROJECT};
        case (r_action)
            ACT_TRANSLATE: begin
                t1_a = op_c;
                t1_b = B_ONE;
                t2_a = A_ONE;
                t2_b = self_c;
            end
            ACT_SCALE: begin
                t1_a = op_c;
                t1_b = self_c;
            end
            ACT_ROTATE: begin
                if (!r_sel) begin
                    t1_a = cos_a;
                    t1_b = self_c;
                    t2_a = -sin_a;
                    t2_b = other_c;
                end else begin
                    t1_a = sin_a;
                    t1_b = other_c;
                    t2_a = cos_a;
                    t2_b = self_c;
                end
            end
            ACT_SHEAR: begin
                t1_a = op_c;
                t1_b = other_c;
            end
            ACT_PROJECT: begin
                t1_a = op_c;
                t1_b = self_c;
            end
            default: begin
                // Unknown actions leave the point where it is.
                t1_a = A_ONE;
                t1_b = self_c;
            end
        endcase
        mac_a      = (r_ph == PH_MUL1) ? t1_a : t2_a;
        mac_b      = (r_ph == PH_MUL1) ? t1_b : t2_b;
        mac_addend = (r_action == ACT_SHEAR) ? self_c : '0;

        mac_ctl.mul_en    = (r_state == S_PT) && ((r_ph == PH_MUL1) || (r_ph == PH_MUL2));
        mac_ctl.acc_load  = (r_state == S_PT) && (r_ph == PH_MUL2);
        mac_ctl.acc_add   = (r_state == S_PT) && (r_ph == PH_SUM);
        mac_ctl.acc_trunc = (r_state == S_PT) && (r_ph == PH_TRUNC) && div_mode;
    end

    pst_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_op_a   (mac_a),
        .i_op_b   (mac_b),
        .i_addend (mac_addend),
        .o_result (mac_result)
    );

    // Screen mapping of the point at the head of the ring. Line ends add x to the centre,
    // bar corners are mirrored about it.
    always_comb begin
        cx_s  = CALC_W'(r_cx);
        cy_s  = CALC_W'(r_cy);
        px    = CALC_W'(r_pt[0]);
        py    = CALC_W'(r_pt[1]);
        scr_x = (!r_pcnt[1]) ? (cx_s + px) : (cx_s - px);
        scr_y = cy_s - py;
    end

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cx        <= CEN_W'(320);
            r_cy        <= CEN_W'(240);
            r_sel       <= 1'b0;
            r_ph        <= PH_MUL1;
            r_pcnt      <= '0;
            r_pt[0]     <= COORD_WIDTH'(0);
            r_pt[1]     <= COORD_WIDTH'(0);
            r_pt[2]     <= COORD_WIDTH'(150);
            r_pt[3]     <= COORD_WIDTH'(150);
            r_pt[4]     <= COORD_WIDTH'(150);
            r_pt[5]     <= COORD_WIDTH'(150);
            r_pt[6]     <= COORD_WIDTH'(100);
            r_pt[7]     <= COORD_WIDTH'(100);
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_CENTER_X) begin
                    r_cx <= i_cfg_data;
                end else if (i_cfg_index == CFG_CENTER_Y) begin
                    r_cy <= i_cfg_data;
                end
            end

            // The output register empties when its item is taken and nothing follows.
            if (i_m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_action <= in_action;
                        r_op_a   <= in_op_a;
                        r_op_b   <= in_op_b;
                        r_sel    <= 1'b0;
                        r_ph     <= PH_MUL1;
                        r_pcnt   <= '0;
                        r_state  <= (in_action == ACT_ROTATE) ? S_TRIG : S_PT;
                    end
                end
                S_TRIG: begin
                    if (cordic_done) begin
                        r_cos   <= cordic_cos;
                        r_sin   <= cordic_sin;
                        r_state <= S_PT;
                    end
                end
                S_PT: begin
                    if (r_ph == PH_WRITE) begin
                        r_ph <= PH_MUL1;
                        if (!r_sel) begin
                            r_new_x <= mac_result;
                            r_sel   <= 1'b1;
                        end else begin
                            // Both new coordinates are ready: move the point to the tail.
                            for (int i = 0; i < 2*NPTS - 2; i++) begin
                                r_pt[i] <= r_pt[i+2];
                            end
                            r_pt[2*NPTS-2] <= r_new_x;
                            r_pt[2*NPTS-1] <= mac_result;
                            r_sel          <= 1'b0;
                            r_pcnt         <= r_pcnt + 1'b1;
                            if (r_pcnt == IDX_W'(NPTS - 1)) begin
                                r_state <= S_OUT;
                            end
                        end
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_last  <= (r_pcnt == IDX_W'(NPTS - 1));
                        r_out_data  <= OUT_TDATA_W'({PAD_W'(0),
                                                     scr_y[SCREEN_W-1:0],
                                                     scr_x[SCREEN_W-1:0],
                                                     py[MODEL_W-1:0],
                                                     px[MODEL_W-1:0],
                                                     r_pcnt});
                        for (int i = 0; i < 2*NPTS - 2; i++) begin
                            r_pt[i] <= r_pt[i+2];
                        end
                        r_pt[2*NPTS-2] <= r_pt[0];
                        r_pt[2*NPTS-1] <= r_pt[1];
                        r_pcnt         <= r_pcnt + 1'b1;
                        if (r_pcnt == IDX_W'(NPTS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import pst_pkg::*;

    // Self-checking bench for the four-point 2D transform unit.
    // A checker object tracks the four points and both screen centres.
    // For every transform item accepted on the input stream, it predicts the four
    // point reports that must follow on the output stream, and it compares each
    // report field by field as it is accepted.

    // Action codes above the last defined one are left unused by the block.
    localparam logic [ACT_W-1:0] ACT_TOP_CODE = '1;

    // Register indexes with no register behind them; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
    localparam longint OP_MAX = (longint'(1) << (OP_W - 1)) - 1;
    localparam longint OP_MIN = -OP_MAX - 1;

    // Cycles without any accepted item on any channel before the run is abandoned.
    // The slowest item is a rotation, which can also meet a stall on each of its four reports.
    localparam int STALL_LIMIT = 4000;

    // Quiet period at the very end to catch reports that nobody asked for.
    localparam int END_SETTLE = 100;

    // Arctangents of 2^-i in Q.16 degrees, indexed by CORDIC step.
    localparam longint ARCTAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117265, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // One point report as it appears on the output stream.
    typedef struct {
        logic [IDX_W-1:0]           index;
        logic signed [MODEL_W-1:0]  model_x;
        logic signed [MODEL_W-1:0]  model_y;
        logic signed [SCREEN_W-1:0] screen_x;
        logic signed [SCREEN_W-1:0] screen_y;
        logic                       last;
    } t_point_report;

    // Tracks the point set and the screen centres, and holds the reports that
    // are owed by the block, oldest first.
    class transform_checker;
        longint        coords[2 * NPTS];
        longint        centre_x;
        longint        centre_y;
        t_point_report owed_reports[$];
        int            errors;

        function new();
            coords   = '{0, 0, 150, 150, 150, 150, 100, 100};
            centre_x = 320;
            centre_y = 240;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CEN_W-1:0] value);
            case (index)
                CFG_CENTER_X: centre_x = longint'(value);
                CFG_CENTER_Y: centre_y = longint'(value);
                default: ;
            endcase
        endfunction

        function longint clamp_coord(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // Cosine and sine of an angle in Q.FRAC_BITS degrees, rounded to
        // Q.FRAC_BITS. The angle is brought into [-180,180) and then folded
        // into [-90,90] by a half-turn, which flips the sign of both results.
        function void cordic_sincos(longint angle, output longint cos_q, output longint sin_q);
            longint full;
            longint half;
            longint quarter;
            longint r;
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            longint rnd;
            bit     flip;
            full    = 360 * ONE_Q;
            half    = 180 * ONE_Q;
            quarter = 90 * ONE_Q;
            r       = ((angle % full) + full) % full;
            flip    = 1'b0;
            if (r >= half) r = r - full;
            if (r > quarter) begin
                r    = r - half;
                flip = 1'b1;
            end else if (r < -quarter) begin
                r    = r + half;
                flip = 1'b1;
            end
            z = r * (longint'(1) << (16 - FRAC_BITS));
            x = 652032874;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ARCTAN_Q16[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ARCTAN_Q16[i];
                end
            end
            rnd   = longint'(1) << (29 - FRAC_BITS);
            cos_q = (x + rnd) >>> (30 - FRAC_BITS);
            sin_q = (y + rnd) >>> (30 - FRAC_BITS);
            if (flip) begin
                cos_q = -cos_q;
                sin_q = -sin_q;
            end
        endfunction

        // Applies one transform to all four points and queues the four reports.
        function void note_transform(logic [ACT_W-1:0] act,
                                     logic signed [OP_W-1:0] op_a,
                                     logic signed [OP_W-1:0] op_b);
            longint        a;
            longint        b;
            longint        cos_q;
            longint        sin_q;
            longint        x;
            longint        y;
            longint        nx;
            longint        ny;
            t_point_report rep;
            a     = op_a;
            b     = op_b;
            cos_q = 0;
            sin_q = 0;
            if (act == ACT_ROTATE) cordic_sincos(a, cos_q, sin_q);
            for (int k = 0; k < NPTS; k++) begin
                x  = coords[2 * k];
                y  = coords[2 * k + 1];
                nx = x;
                ny = y;
                case (act)
                    ACT_TRANSLATE: begin
                        nx = x + a;
                        ny = y + b;
                    end
                    ACT_SCALE: begin
                        nx = x * a;
                        ny = y * b;
                    end
                    ACT_ROTATE: begin
                        nx = (x * cos_q - y * sin_q) / ONE_Q;
                        ny = (x * sin_q + y * cos_q) / ONE_Q;
                    end
                    ACT_SHEAR: begin
                        nx = x + (y * a) / ONE_Q;
                        ny = y + (x * b) / ONE_Q;
                    end
                    ACT_PROJECT: begin
                        nx = (x * a) / ONE_Q;
                        ny = (y * b) / ONE_Q;
                    end
                    default: ;
                endcase
                coords[2 * k]     = clamp_coord(nx);
                coords[2 * k + 1] = clamp_coord(ny);
            end
            for (int k = 0; k < NPTS; k++) begin
                x            = coords[2 * k];
                y            = coords[2 * k + 1];
                rep.index    = IDX_W'(k);
                rep.model_x  = MODEL_W'(x);
                rep.model_y  = MODEL_W'(y);
                // Bar corners are mirrored about the screen centre.
                rep.screen_x = SCREEN_W'((k < 2) ? centre_x + x : centre_x - x);
                rep.screen_y = SCREEN_W'(centre_y - y);
                rep.last     = (k == NPTS - 1);
                owed_reports.push_back(rep);
            end
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic [OUT_TDATA_W-1:0] data, logic tlast);
            t_point_report got;
            t_point_report want;
            got.index    = data[IDX_W-1:0];
            got.model_x  = data[IDX_W +: MODEL_W];
            got.model_y  = data[IDX_W + MODEL_W +: MODEL_W];
            got.screen_x = data[IDX_W + 2 * MODEL_W +: SCREEN_W];
            got.screen_y = data[IDX_W + 2 * MODEL_W + SCREEN_W +: SCREEN_W];
            got.last     = tlast;
            if (owed_reports.size() == 0) begin
                $error("point report %0d arrived with none outstanding", got.index);
                errors++;
                return;
            end
            want = owed_reports.pop_front();
            compare_field("point_index", want.index, got.index);
            compare_field("model_x", want.model_x, got.model_x);
            compare_field("model_y", want.model_y, got.model_y);
            compare_field("screen_x", want.screen_x, got.screen_x);
            compare_field("screen_y", want.screen_y, got.screen_y);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    // Every input of the block holds a known value from time zero onwards.
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic [ACT_W-1:0]       i_s_axis_tuser  = '0;
    logic                   i_m_axis_tready = 1'b0;
    logic                   i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index     = '0;
    logic [CEN_W-1:0]       i_cfg_data      = '0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic                   o_cfg_ready;

    transform_checker chk;

    // Random idling on both streams is switched on and off by the stimulus.
    bit gaps_on    = 1'b0;
    int stall_left = 0;
    int idle_count = 0;

    point_set_2d_transform_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Observes every handshake at the clock edge. Reports are checked before
    // new items are noted, so that a stray report can never be matched against
    // an expectation raised at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                chk.check_report(o_m_axis_tdata, o_m_axis_tlast);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                chk.note_transform(i_s_axis_tuser,
                                   i_s_axis_tdata[0 +: OP_W],
                                   i_s_axis_tdata[OP_W +: OP_W]);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                chk.write_reg(i_cfg_index, i_cfg_data);
            end
        end
    end

    // The result side stalls in random bursts while gaps are on.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= int'($urandom_range(0, 5));
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Gives up when no channel has moved an item for too long.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    function automatic longint rand_span(longint lo, longint hi);
        return lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    // Any value of a 24-bit signed operand.
    function automatic longint rand_op();
        logic signed [OP_W-1:0] v;
        v = OP_W'($urandom);
        return v;
    endfunction

    // A magnitude in [lo, hi] with a random sign.
    function automatic longint signed_gain(longint lo, longint hi);
        longint m;
        m = rand_span(lo, hi);
        return ($urandom_range(0, 1) != 0) ? m : -m;
    endfunction

    // Offers one transform item and returns at the edge where it is taken.
    // An optional gap comes first, so that valid is never dropped and raised
    // again within one time step.
    task automatic send_transform(input logic [ACT_W-1:0] act, input longint op_a,
                                  input longint op_b);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= act;
        i_s_axis_tdata  <= IN_TDATA_W'({op_b[OP_W-1:0], op_a[OP_W-1:0]});
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Mostly transforms that keep the points in a useful range; in wild mode a
    // third of the items carry arbitrary operands, which drives saturation.
    task automatic random_transform(input bit wild);
        logic [ACT_W-1:0] act;
        longint           a;
        longint           b;
        if ($urandom_range(0, 24) == 0) begin
            act = ACT_W'($urandom_range(ACT_PROJECT + 1, ACT_TOP_CODE));
        end else begin
            act = ACT_W'($urandom_range(ACT_TRANSLATE, ACT_PROJECT));
        end
        a = rand_op();
        b = rand_op();
        if (!wild || $urandom_range(0, 2) != 0) begin
            case (act)
                ACT_TRANSLATE: begin
                    a = rand_span(-400, 400);
                    b = rand_span(-400, 400);
                end
                ACT_SCALE: begin
                    a = signed_gain(1, ($urandom_range(0, 4) == 0) ? 2 : 1);
                    b = signed_gain(1, ($urandom_range(0, 4) == 0) ? 2 : 1);
                end
                ACT_ROTATE: begin
                    // Half of the angles span the whole operand range.
                    if ($urandom_range(0, 1) != 0) a = rand_span(-720 * ONE_Q, 720 * ONE_Q);
                end
                ACT_SHEAR: begin
                    a = rand_span(-ONE_Q, ONE_Q);
                    b = rand_span(-ONE_Q, ONE_Q);
                end
                ACT_PROJECT: begin
                    a = signed_gain(ONE_Q * 3 / 4, ONE_Q * 5 / 4);
                    b = signed_gain(ONE_Q * 3 / 4, ONE_Q * 5 / 4);
                end
                default: ;
            endcase
        end
        send_transform(act, a, b);
    endtask

    task automatic random_phase(input int count, input bit wild);
        for (int n = 0; n < count; n++) begin
            // Stretches with and without idling alternate at random.
            if (n % 10 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            random_transform(wild);
        end
    endtask

    // Stops offering items and waits until every owed report has arrived.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk.owed_reports.size() != 0) @(posedge i_clk);
    endtask

    // Leaves valid high so that back-to-back writes need no drop in between.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CEN_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes both centres, optionally preceded by writes to the unused indexes,
    // which must leave the centres alone.
    task automatic set_centres(input logic [CEN_W-1:0] cx, input logic [CEN_W-1:0] cy,
                               input bit with_spare);
        if (with_spare) begin
            write_reg(CFG_SPARE_A, CEN_W'($urandom));
            write_reg(CFG_SPARE_B, CEN_W'($urandom));
        end
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        chk = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items with the reset centres: rotation through every quadrant
        // and across the folding boundaries, the other actions with moderate
        // factors, and the unused action codes.
        gaps_on = 1'b1;
        send_transform(ACT_TRANSLATE, 0, 0);
        send_transform(ACT_TRANSLATE, 100, -50);
        send_transform(ACT_SCALE, 1, -1);
        send_transform(ACT_ROTATE, 90 * ONE_Q, 0);
        send_transform(ACT_ROTATE, 90 * ONE_Q + 1, OP_MAX);
        send_transform(ACT_ROTATE, -90 * ONE_Q, 0);
        send_transform(ACT_ROTATE, 180 * ONE_Q, 0);
        send_transform(ACT_ROTATE, -180 * ONE_Q, 0);
        send_transform(ACT_ROTATE, 270 * ONE_Q, 0);
        send_transform(ACT_ROTATE, 45 * ONE_Q + ONE_Q / 2, 0);
        send_transform(ACT_ROTATE, 750 * ONE_Q, 0);
        send_transform(ACT_ROTATE, OP_MAX, OP_MIN);
        send_transform(ACT_ROTATE, OP_MIN, OP_MAX);
        send_transform(ACT_SHEAR, ONE_Q / 2, -ONE_Q / 4);
        send_transform(ACT_PROJECT, ONE_Q, -ONE_Q);
        send_transform(ACT_PROJECT, ONE_Q * 3 / 2, ONE_Q * 3 / 4);
        send_transform(ACT_SCALE, 2, 1);
        send_transform(ACT_W'(ACT_PROJECT + 1), OP_MAX, OP_MIN);
        send_transform(ACT_TOP_CODE, OP_MIN, OP_MAX);
        drain();

        // Both centres at their lowest, then at their highest.
        set_centres('0, '0, 1'b0);
        random_phase(40, 1'b0);
        drain();
        set_centres('1, '1, 1'b1);
        random_phase(40, 1'b0);
        drain();

        // Saturation corners come late, since they pull the points onto the
        // range limits and collapse much of the shape.
        set_centres(CEN_W'($urandom), CEN_W'($urandom), 1'b1);
        gaps_on = 1'b1;
        send_transform(ACT_TRANSLATE, OP_MAX, OP_MIN);
        send_transform(ACT_SCALE, OP_MIN, OP_MAX);
        send_transform(ACT_SHEAR, OP_MAX, OP_MIN);
        send_transform(ACT_PROJECT, OP_MIN, OP_MAX);
        send_transform(ACT_PROJECT, 0, 0);
        send_transform(ACT_TRANSLATE, OP_MIN, OP_MAX);
        random_phase(30, 1'b1);

        // The closing stretch runs with both sides flat out.
        gaps_on = 1'b0;
        for (int n = 0; n < 25; n++) random_transform(1'b1);
        drain();
        repeat (END_SETTLE) @(posedge i_clk);

        if (chk.errors == 0 && chk.owed_reports.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
